// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, payload types and the controller/datapath command set of
// the buddy page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int PAGE_COUNT = 65536;
  localparam int TOP_ORDER  = 11;
  localparam int PAGE_SHIFT = 12;

  localparam int ADDR_W    = 48;
  localparam int CNT_W     = 17;
  localparam int ORD_IN_W  = 4;
  localparam int OFF_W     = $clog2(PAGE_COUNT);
  localparam int PG_W      = ADDR_W - PAGE_SHIFT;
  localparam int NUM_LISTS = TOP_ORDER + 1;
  localparam int ORD_W     = $clog2(NUM_LISTS);

  // Configuration register indexes.
  localparam logic [1:0] CFG_REGION_BASE    = 2'd0;
  localparam logic [1:0] CFG_REGION_PAGES   = 2'd1;
  localparam logic [1:0] CFG_RESERVED_BASE  = 2'd2;
  localparam logic [1:0] CFG_RESERVED_PAGES = 2'd3;

  localparam logic [ADDR_W-1:0] RST_REGION_BASE    = 48'd1073741824;
  localparam logic [CNT_W-1:0]  RST_REGION_PAGES   = 17'd65536;
  localparam logic [ADDR_W-1:0] RST_RESERVED_BASE  = 48'd0;
  localparam logic [CNT_W-1:0]  RST_RESERVED_PAGES = 17'd0;

  // Request functions and result status codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMEM  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // Datapath operations.
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] DP_NOP         = 5'd0;
  localparam logic [OP_W-1:0] DP_BUILD_INIT  = 5'd1;
  localparam logic [OP_W-1:0] DP_BUILD_STEP  = 5'd2;
  localparam logic [OP_W-1:0] DP_LOAD        = 5'd3;
  localparam logic [OP_W-1:0] DP_POP_READ    = 5'd4;
  localparam logic [OP_W-1:0] DP_POP_WRITE   = 5'd5;
  localparam logic [OP_W-1:0] DP_SPLIT       = 5'd6;
  localparam logic [OP_W-1:0] DP_SCAN_INIT   = 5'd7;
  localparam logic [OP_W-1:0] DP_SCAN_READ   = 5'd8;
  localparam logic [OP_W-1:0] DP_SCAN_NEXT   = 5'd9;
  localparam logic [OP_W-1:0] DP_ANC_INIT    = 5'd10;
  localparam logic [OP_W-1:0] DP_ANC_READ    = 5'd11;
  localparam logic [OP_W-1:0] DP_ANC_NEXT    = 5'd12;
  localparam logic [OP_W-1:0] DP_MRG_INIT    = 5'd13;
  localparam logic [OP_W-1:0] DP_BUDDY_READ  = 5'd14;
  localparam logic [OP_W-1:0] DP_UNLINK_HEAD = 5'd15;
  localparam logic [OP_W-1:0] DP_WALK_INIT   = 5'd16;
  localparam logic [OP_W-1:0] DP_CUR_READ    = 5'd17;
  localparam logic [OP_W-1:0] DP_UNLINK_MID  = 5'd18;
  localparam logic [OP_W-1:0] DP_WALK_NEXT   = 5'd19;
  localparam logic [OP_W-1:0] DP_CLR_B       = 5'd20;
  localparam logic [OP_W-1:0] DP_PUSH        = 5'd21;
  localparam logic [OP_W-1:0] DP_FINISH      = 5'd22;

  typedef struct packed {
    logic                func;
    logic [ORD_IN_W-1:0] block_order;
    logic [ADDR_W-1:0]   block_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [1:0]        status;
    logic [CNT_W-1:0]  free_pages;
  } out_item_t;

  // One page store entry: free head mark, block order and next link.
  typedef struct packed {
    logic             mark;
    logic [ORD_W-1:0] ord;
    logic             lv;
    logic [OFF_W-1:0] link;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      res;
  } cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic build_last;
    logic ord_bad;
    logic is_alloc;
    logic found;
    logic free_bad;
    logic split_more;
    logic split_last;
    logic rd_mark;
    logic scan_last;
    logic anc_hit;
    logic anc_last;
    logic mrg_stop;
    logic bud_ok;
    logic b_is_head;
    logic head_valid_cur;
    logic walk_found;
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpa_ctrl
// Controller of the buddy page allocator: sequences list rebuilds, allocate
// and free requests, and issues one datapath operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ctrl import bpa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [4:0] S_BUILD_INIT = 5'd0;
  localparam logic [4:0] S_BUILD      = 5'd1;
  localparam logic [4:0] S_IDLE       = 5'd2;
  localparam logic [4:0] S_DECODE     = 5'd3;
  localparam logic [4:0] S_POP_WAIT   = 5'd4;
  localparam logic [4:0] S_SPLIT      = 5'd5;
  localparam logic [4:0] S_SCAN_RD    = 5'd6;
  localparam logic [4:0] S_SCAN_CHK   = 5'd7;
  localparam logic [4:0] S_ANC_RD     = 5'd8;
  localparam logic [4:0] S_ANC_CHK    = 5'd9;
  localparam logic [4:0] S_MRG_TEST   = 5'd10;
  localparam logic [4:0] S_MRG_BCHK   = 5'd11;
  localparam logic [4:0] S_WALK_RD    = 5'd12;
  localparam logic [4:0] S_WALK_CHK   = 5'd13;
  localparam logic [4:0] S_CLR_B      = 5'd14;
  localparam logic [4:0] S_PUSH       = 5'd15;
  localparam logic [4:0] S_DONE       = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic [1:0] res_r, res_nxt;

  // A register write wins over a request in the same cycle.
  assign in_stall = (state_r != S_IDLE) || sts.cfg_hit;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd.op    = DP_NOP;
    cmd.res   = res_r;
    if (sts.cfg_hit) begin
      state_nxt = S_BUILD_INIT;
    end else begin
      unique case (state_r)
        S_BUILD_INIT: begin
          cmd.op    = DP_BUILD_INIT;
          state_nxt = S_BUILD;
        end
        S_BUILD: begin
          cmd.op = DP_BUILD_STEP;
          if (sts.build_last) state_nxt = S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd.op    = DP_LOAD;
            state_nxt = S_DECODE;
          end
        end
        S_DECODE: begin
          priority if (sts.ord_bad) begin
            res_nxt   = ST_REJECT;
            state_nxt = S_DONE;
          end else if (sts.is_alloc && !sts.found) begin
            res_nxt   = ST_NOMEM;
            state_nxt = S_DONE;
          end else if (sts.is_alloc) begin
            cmd.op    = DP_POP_READ;
            state_nxt = S_POP_WAIT;
          end else if (sts.free_bad) begin
            res_nxt   = ST_REJECT;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = DP_SCAN_INIT;
            state_nxt = S_SCAN_RD;
          end
        end
        S_POP_WAIT: begin
          cmd.op    = DP_POP_WRITE;
          res_nxt   = ST_OK;
          state_nxt = sts.split_more ? S_SPLIT : S_DONE;
        end
        S_SPLIT: begin
          cmd.op = DP_SPLIT;
          if (sts.split_last) state_nxt = S_DONE;
        end
        S_SCAN_RD: begin
          cmd.op    = DP_SCAN_READ;
          state_nxt = S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          priority if (sts.rd_mark) begin
            res_nxt   = ST_REJECT;
            state_nxt = S_DONE;
          end else if (sts.scan_last) begin
            cmd.op    = DP_ANC_INIT;
            state_nxt = S_ANC_RD;
          end else begin
            cmd.op    = DP_SCAN_NEXT;
            state_nxt = S_SCAN_RD;
          end
        end
        S_ANC_RD: begin
          cmd.op    = DP_ANC_READ;
          state_nxt = S_ANC_CHK;
        end
        S_ANC_CHK: begin
          priority if (sts.anc_hit) begin
            res_nxt   = ST_REJECT;
            state_nxt = S_DONE;
          end else if (sts.anc_last) begin
            cmd.op    = DP_MRG_INIT;
            state_nxt = S_MRG_TEST;
          end else begin
            cmd.op    = DP_ANC_NEXT;
            state_nxt = S_ANC_RD;
          end
        end
        S_MRG_TEST: begin
          if (sts.mrg_stop) begin
            state_nxt = S_PUSH;
          end else begin
            cmd.op    = DP_BUDDY_READ;
            state_nxt = S_MRG_BCHK;
          end
        end
        S_MRG_BCHK: begin
          priority if (!sts.bud_ok) begin
            state_nxt = S_PUSH;
          end else if (sts.b_is_head) begin
            cmd.op    = DP_UNLINK_HEAD;
            state_nxt = S_MRG_TEST;
          end else if (!sts.head_valid_cur) begin
            state_nxt = S_PUSH;
          end else begin
            cmd.op    = DP_WALK_INIT;
            state_nxt = S_WALK_RD;
          end
        end
        S_WALK_RD: begin
          cmd.op    = DP_CUR_READ;
          state_nxt = S_WALK_CHK;
        end
        S_WALK_CHK: begin
          priority if (sts.walk_found) begin
            cmd.op    = DP_UNLINK_MID;
            state_nxt = S_CLR_B;
          end else if (sts.walk_end) begin
            state_nxt = S_PUSH;
          end else begin
            cmd.op    = DP_WALK_NEXT;
            state_nxt = S_WALK_RD;
          end
        end
        S_CLR_B: begin
          cmd.op    = DP_CLR_B;
          state_nxt = S_MRG_TEST;
        end
        S_PUSH: begin
          cmd.op    = DP_PUSH;
          res_nxt   = ST_OK;
          state_nxt = S_DONE;
        end
        S_DONE: begin
          if (sts.out_free) begin
            cmd.op    = DP_FINISH;
            state_nxt = S_IDLE;
          end
        end
        default: begin
          state_nxt = S_BUILD_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BUILD_INIT;
      res_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/bpa_datapath.sv =====
// ----------------------------------------------------------------------------
// bpa_datapath
// Datapath of the buddy page allocator: configuration registers, list heads,
// free page counter, the page store and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_datapath import bpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  input  wire in_item_t          in_data,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output out_item_t              out_data,
  input  wire cmd_t              cmd,
  output sts_t                   sts
);

  localparam int SW = PG_W + 2;

  logic [ADDR_W-1:0]     region_base_r, region_base_nxt;
  logic [CNT_W-1:0]      region_pages_r, region_pages_nxt;
  logic [ADDR_W-1:0]     resv_base_r, resv_base_nxt;
  logic [CNT_W-1:0]      resv_pages_r, resv_pages_nxt;
  logic [PG_W-1:0]       bp_r, bp_nxt;
  logic [CNT_W-1:0]      live_r, live_nxt;
  logic signed [SW-1:0]  rlo_r, rlo_nxt;
  logic signed [SW-1:0]  rhi_r, rhi_nxt;
  logic [CNT_W-1:0]      run_lo_r, run_lo_nxt;
  logic [OFF_W-1:0]      heads_r [NUM_LISTS];
  logic [OFF_W-1:0]      heads_nxt [NUM_LISTS];
  logic [NUM_LISTS-1:0]  hv_r, hv_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [OFF_W-1:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0]      blk_r, blk_nxt;
  logic                  func_r, func_nxt;
  logic [ORD_IN_W-1:0]   ord_r, ord_nxt;
  logic [PG_W:0]         off_full_r, off_full_nxt;
  logic                  addr_lo_bad_r, addr_lo_bad_nxt;
  logic [OFF_W-1:0]      off_r, off_nxt;
  logic [ORD_W-1:0]      cur_o_r, cur_o_nxt;
  logic [OFF_W-1:0]      cur_r, cur_nxt;
  ent_t                  eb_r, eb_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic             ram_we, ram_re;
  logic [OFF_W-1:0] ram_waddr, ram_raddr;
  ent_t             ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  ent_t             rd;

  bpa_ram #(
    .WIDTH(ENT_W),
    .DEPTH(PAGE_COUNT)
  ) u_page_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd = ent_t'(ram_rdata);

  // Rebuild bounds, taken straight from the configuration registers.
  logic [PG_W-1:0]      bp_w;
  logic [PG_W:0]        room_w;
  logic [CNT_W-1:0]     n_w;
  logic signed [SW-1:0] rlo_w;
  logic signed [SW-1:0] n_sgn;

  always_comb begin
    bp_w   = region_base_r[ADDR_W-1:PAGE_SHIFT];
    room_w = {1'b1, {PG_W{1'b0}}} - {1'b0, bp_w};
    n_w    = region_pages_r;
    if (n_w > CNT_W'(PAGE_COUNT)) n_w = CNT_W'(PAGE_COUNT);
    if ({{(PG_W + 1 - CNT_W){1'b0}}, n_w} > room_w) n_w = room_w[CNT_W-1:0];
    rlo_w = $signed({2'b00, resv_base_r[ADDR_W-1:PAGE_SHIFT]}) - $signed({2'b00, bp_w});
    n_sgn = $signed({{(SW - CNT_W){1'b0}}, n_w});
  end

  // Build sweep: pick the largest aligned block that fits the free run.
  logic [CNT_W-1:0]     ptr_ext;
  logic signed [SW-1:0] p_sgn;
  logic                 resv_w, is_head_w;
  logic [CNT_W-1:0]     run_end_w, span_w;
  logic [ORD_W-1:0]     bo_w;

  always_comb begin
    ptr_ext   = {1'b0, ptr_r};
    p_sgn     = $signed({{(SW - OFF_W){1'b0}}, ptr_r});
    resv_w    = (p_sgn >= rlo_r) && (p_sgn < rhi_r);
    is_head_w = (ptr_ext == blk_r) && (ptr_ext < live_r);
    run_end_w = (p_sgn < rlo_r) ? run_lo_r : live_r;
    span_w    = run_end_w - ptr_ext;
    bo_w      = '0;
    for (int o = 0; o <= TOP_ORDER; o++) begin
      if (((ptr_ext & ((CNT_W'(1) << o) - CNT_W'(1))) == '0) &&
          ((CNT_W'(1) << o) <= span_w)) begin
        bo_w = ORD_W'(o);
      end
    end
  end

  // Request side helpers.
  logic [CNT_W-1:0] cnt_w;
  logic [OFF_W-1:0] b_w, anc_a_w, split_x_w, merged_off_w;
  logic [ORD_W-1:0] split_o_w, found_o_w;
  logic             found_w;
  logic [PG_W:0]    off_end_w;

  always_comb begin
    cnt_w        = CNT_W'(1) << ord_r;
    b_w          = off_r ^ (OFF_W'(1) << cur_o_r);
    merged_off_w = off_r & ~(OFF_W'(1) << cur_o_r);
    anc_a_w      = off_r & ~((OFF_W'(1) << cur_o_r) - OFF_W'(1));
    split_o_w    = cur_o_r - ORD_W'(1);
    split_x_w    = off_r ^ (OFF_W'(1) << split_o_w);
    off_end_w    = {1'b0, off_full_r[PG_W-1:0]} + {{(PG_W + 1 - CNT_W){1'b0}}, cnt_w};
    found_w      = 1'b0;
    found_o_w    = '0;
    for (int o = TOP_ORDER; o >= 0; o--) begin
      if (hv_r[o] && (o >= int'(ord_r))) begin
        found_w   = 1'b1;
        found_o_w = ORD_W'(o);
      end
    end
  end

  always_comb begin
    sts.cfg_hit        = cfg_we;
    sts.build_last     = (ptr_r == {OFF_W{1'b1}});
    sts.ord_bad        = (ord_r > ORD_IN_W'(TOP_ORDER));
    sts.is_alloc       = (func_r == FUNC_ALLOC);
    sts.found          = found_w;
    sts.free_bad       = addr_lo_bad_r || off_full_r[PG_W] ||
                         (off_full_r[PG_W-1:0] >= {{(PG_W - CNT_W){1'b0}}, live_r}) ||
                         (off_end_w > {{(PG_W + 1 - CNT_W){1'b0}}, live_r}) ||
                         ((off_full_r[CNT_W-1:0] & (cnt_w - CNT_W'(1))) != '0);
    sts.split_more     = (cur_o_r != ORD_W'(ord_r));
    sts.split_last     = (split_o_w == ORD_W'(ord_r));
    sts.rd_mark        = rd.mark;
    sts.scan_last      = (ptr_r == (off_r | OFF_W'(cnt_w - CNT_W'(1))));
    sts.anc_hit        = (anc_a_w < off_r) && rd.mark && (rd.ord <= ORD_W'(TOP_ORDER)) &&
                         (({1'b0, anc_a_w} + (CNT_W'(1) << rd.ord)) > {1'b0, off_r});
    sts.anc_last       = (cur_o_r == ORD_W'(TOP_ORDER));
    sts.mrg_stop       = (cur_o_r >= ORD_W'(TOP_ORDER)) || ({1'b0, b_w} >= live_r);
    sts.bud_ok         = rd.mark && (rd.ord == cur_o_r);
    sts.b_is_head      = hv_r[cur_o_r] && (heads_r[cur_o_r] == b_w);
    sts.head_valid_cur = hv_r[cur_o_r];
    sts.walk_found     = rd.lv && (rd.link == b_w);
    sts.walk_end       = !rd.lv;
    sts.out_free       = !out_valid_r || !out_stall;
  end

  always_comb begin
    region_base_nxt  = region_base_r;
    region_pages_nxt = region_pages_r;
    resv_base_nxt    = resv_base_r;
    resv_pages_nxt   = resv_pages_r;
    bp_nxt           = bp_r;
    live_nxt         = live_r;
    rlo_nxt          = rlo_r;
    rhi_nxt          = rhi_r;
    run_lo_nxt       = run_lo_r;
    heads_nxt        = heads_r;
    hv_nxt           = hv_r;
    total_nxt        = total_r;
    ptr_nxt          = ptr_r;
    blk_nxt          = blk_r;
    func_nxt         = func_r;
    ord_nxt          = ord_r;
    off_full_nxt     = off_full_r;
    addr_lo_bad_nxt  = addr_lo_bad_r;
    off_nxt          = off_r;
    cur_o_nxt        = cur_o_r;
    cur_nxt          = cur_r;
    eb_nxt           = eb_r;
    out_data_nxt     = out_data_r;
    out_valid_nxt    = out_valid_r && out_stall;
    ram_we           = 1'b0;
    ram_waddr        = ptr_r;
    ram_wdata        = '0;
    ram_re           = 1'b0;
    ram_raddr        = ptr_r;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_REGION_BASE:    region_base_nxt  = cfg_wdata;
        CFG_REGION_PAGES:   region_pages_nxt = cfg_wdata[CNT_W-1:0];
        CFG_RESERVED_BASE:  resv_base_nxt    = cfg_wdata;
        CFG_RESERVED_PAGES: resv_pages_nxt   = cfg_wdata[CNT_W-1:0];
      endcase
    end

    unique case (cmd.op)
      DP_BUILD_INIT: begin
        bp_nxt    = bp_w;
        live_nxt  = n_w;
        rlo_nxt   = rlo_w;
        rhi_nxt   = rlo_w + $signed({{(SW - CNT_W){1'b0}}, resv_pages_r});
        // The first free run ends at the reserved range only if that range
        // starts inside the region.
        if ((resv_pages_r != '0) && (rlo_w >= 0) && (rlo_w < n_sgn)) begin
          run_lo_nxt = rlo_w[CNT_W-1:0];
        end else begin
          run_lo_nxt = n_w;
        end
        hv_nxt    = '0;
        total_nxt = '0;
        ptr_nxt   = '0;
        blk_nxt   = '0;
      end
      DP_BUILD_STEP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        if (is_head_w && !resv_w) begin
          ram_wdata.mark    = 1'b1;
          ram_wdata.ord     = bo_w;
          ram_wdata.lv      = hv_r[bo_w];
          ram_wdata.link    = heads_r[bo_w];
          heads_nxt[bo_w]   = ptr_r;
          hv_nxt[bo_w]      = 1'b1;
          total_nxt         = total_r + (CNT_W'(1) << bo_w);
          blk_nxt           = blk_r + (CNT_W'(1) << bo_w);
        end else if (is_head_w) begin
          blk_nxt = blk_r + CNT_W'(1);
        end
        ptr_nxt = ptr_r + OFF_W'(1);
      end
      DP_LOAD: begin
        func_nxt        = in_data.func;
        ord_nxt         = in_data.block_order;
        off_full_nxt    = {1'b0, in_data.block_address[ADDR_W-1:PAGE_SHIFT]} - {1'b0, bp_r};
        addr_lo_bad_nxt = (in_data.block_address[PAGE_SHIFT-1:0] != '0);
      end
      DP_POP_READ: begin
        cur_o_nxt = found_o_w;
        off_nxt   = heads_r[found_o_w];
        ram_re    = 1'b1;
        ram_raddr = heads_r[found_o_w];
      end
      DP_POP_WRITE: begin
        heads_nxt[cur_o_r] = rd.link;
        hv_nxt[cur_o_r]    = rd.lv;
        ram_we             = 1'b1;
        ram_waddr          = off_r;
        ram_wdata          = rd;
        ram_wdata.mark     = 1'b0;
        ram_wdata.lv       = 1'b0;
      end
      DP_SPLIT: begin
        cur_o_nxt            = split_o_w;
        ram_we               = 1'b1;
        ram_waddr            = split_x_w;
        ram_wdata.mark       = 1'b1;
        ram_wdata.ord        = split_o_w;
        ram_wdata.lv         = hv_r[split_o_w];
        ram_wdata.link       = heads_r[split_o_w];
        heads_nxt[split_o_w] = split_x_w;
        hv_nxt[split_o_w]    = 1'b1;
      end
      DP_SCAN_INIT: begin
        off_nxt = off_full_r[OFF_W-1:0];
        ptr_nxt = off_full_r[OFF_W-1:0];
      end
      DP_SCAN_READ: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_r;
      end
      DP_SCAN_NEXT: begin
        ptr_nxt = ptr_r + OFF_W'(1);
      end
      DP_ANC_INIT: begin
        cur_o_nxt = ORD_W'(1);
      end
      DP_ANC_READ: begin
        ram_re    = 1'b1;
        ram_raddr = anc_a_w;
      end
      DP_ANC_NEXT: begin
        cur_o_nxt = cur_o_r + ORD_W'(1);
      end
      DP_MRG_INIT: begin
        cur_o_nxt = ORD_W'(ord_r);
      end
      DP_BUDDY_READ: begin
        ram_re    = 1'b1;
        ram_raddr = b_w;
      end
      DP_UNLINK_HEAD: begin
        heads_nxt[cur_o_r] = rd.link;
        hv_nxt[cur_o_r]    = rd.lv;
        ram_we             = 1'b1;
        ram_waddr          = b_w;
        ram_wdata          = rd;
        ram_wdata.mark     = 1'b0;
        ram_wdata.lv       = 1'b0;
        off_nxt            = merged_off_w;
        cur_o_nxt          = cur_o_r + ORD_W'(1);
      end
      DP_WALK_INIT: begin
        eb_nxt  = rd;
        cur_nxt = heads_r[cur_o_r];
      end
      DP_CUR_READ: begin
        ram_re    = 1'b1;
        ram_raddr = cur_r;
      end
      DP_UNLINK_MID: begin
        // The predecessor now skips over the buddy.
        ram_we         = 1'b1;
        ram_waddr      = cur_r;
        ram_wdata      = rd;
        ram_wdata.link = eb_r.link;
        ram_wdata.lv   = eb_r.lv;
      end
      DP_WALK_NEXT: begin
        cur_nxt = rd.link;
      end
      DP_CLR_B: begin
        ram_we         = 1'b1;
        ram_waddr      = b_w;
        ram_wdata      = eb_r;
        ram_wdata.mark = 1'b0;
        ram_wdata.lv   = 1'b0;
        off_nxt        = merged_off_w;
        cur_o_nxt      = cur_o_r + ORD_W'(1);
      end
      DP_PUSH: begin
        ram_we             = 1'b1;
        ram_waddr          = off_r;
        ram_wdata.mark     = 1'b1;
        ram_wdata.ord      = cur_o_r;
        ram_wdata.lv       = hv_r[cur_o_r];
        ram_wdata.link     = heads_r[cur_o_r];
        heads_nxt[cur_o_r] = off_r;
        hv_nxt[cur_o_r]    = 1'b1;
      end
      DP_FINISH: begin
        out_valid_nxt               = 1'b1;
        out_data_nxt.status         = cmd.res;
        out_data_nxt.result_address = '0;
        if (cmd.res == ST_OK) begin
          if (func_r == FUNC_ALLOC) begin
            total_nxt = total_r - cnt_w;
            out_data_nxt.result_address =
              {bp_r + {{(PG_W - OFF_W){1'b0}}, off_r}, {PAGE_SHIFT{1'b0}}};
          end else begin
            total_nxt = total_r + cnt_w;
          end
        end
        out_data_nxt.free_pages = (cmd.res == ST_OK) ? total_nxt : total_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r  <= RST_REGION_BASE;
      region_pages_r <= RST_REGION_PAGES;
      resv_base_r    <= RST_RESERVED_BASE;
      resv_pages_r   <= RST_RESERVED_PAGES;
      hv_r           <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      region_base_r  <= region_base_nxt;
      region_pages_r <= region_pages_nxt;
      resv_base_r    <= resv_base_nxt;
      resv_pages_r   <= resv_pages_nxt;
      hv_r           <= hv_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bp_r          <= bp_nxt;
    live_r        <= live_nxt;
    rlo_r         <= rlo_nxt;
    rhi_r         <= rhi_nxt;
    run_lo_r      <= run_lo_nxt;
    heads_r       <= heads_nxt;
    total_r       <= total_nxt;
    ptr_r         <= ptr_nxt;
    blk_r         <= blk_nxt;
    func_r        <= func_nxt;
    ord_r         <= ord_nxt;
    off_full_r    <= off_full_nxt;
    addr_lo_bad_r <= addr_lo_bad_nxt;
    off_r         <= off_nxt;
    cur_o_r       <= cur_o_nxt;
    cur_r         <= cur_nxt;
    eb_r          <= eb_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/buddy_page_allocator_top.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Buddy allocator over a page region with per-order LIFO free lists.
// ----------------------------------------------------------------------------
// After reset and after every register write the block sweeps its 65536-entry
// page store once, one entry per cycle, to rebuild the free lists, with
// in_stall high throughout. Requests are handled one at a time, each through
// the one read and one write port of the page store. An allocate pops the
// smallest free block of large enough order and splits it down as needed. A
// free scans every page of the block for a double free, checks the enclosing
// blocks, then merges with each free buddy, unlinking it at once if it heads
// its list or else after walking its list up to it. A finished result waits
// in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator_top import bpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data
);

  cmd_t cmd;
  sts_t sts;

  bpa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  bpa_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

  // A request keeps the block busy in the following cycle.
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted on consecutive cycles");

  // A register write always starts a rebuild.
  a_rebuild_on_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("register write did not stall requests");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_NOMEM ||
                   out_data.status == ST_REJECT))
    else $error("unknown status code");

  // Only a successful allocate reports an address.
  a_addr_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.result_address == '0))
    else $error("address reported on a failed request");

endmodule

`default_nettype wire
